[sv/sgpw_pkg.sv]
// sgpw_pkg: widths, register codes, payload and control types for stereo_gain_pan_width
// shared by every module of the block; depends on nothing
`default_nettype none

package sgpw_pkg;

  localparam int SAMPLE_BITS     = 24;
  localparam int RAMP_COUNT_BITS = 16;
  localparam int CTRL_BITS       = 24;
  localparam int EXTRA_FRAC      = 7;
  localparam int VAL_BITS        = 32;
  localparam int CW              = VAL_BITS - EXTRA_FRAC;  // smoothed control width
  localparam int AW              = SAMPLE_BITS + 10;       // working sample width
  localparam int PW              = AW + CW + 1;            // product width
  localparam int WIDE            = SAMPLE_BITS + 14;       // width before saturation
  localparam int DIV_W           = VAL_BITS + 1;           // signed ramp difference
  localparam int CFG_IDX_W       = 3;

  localparam int GAIN_SH = 20;
  localparam int PAN_SH  = 22;
  localparam int SIDE_SH = 23;

  localparam logic [CTRL_BITS-1:0]       GAIN_RESET     = CTRL_BITS'(1 << 20);
  localparam logic [CTRL_BITS-1:0]       PAN_RESET      = CTRL_BITS'(1 << 22);
  localparam logic [RAMP_COUNT_BITS-1:0] RAMP_LEN_RESET = RAMP_COUNT_BITS'(882);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_L = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_R = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd5;

  // ramp slots
  localparam int RAMP_GAIN  = 0;
  localparam int RAMP_PAN_L = 1;
  localparam int RAMP_PAN_R = 2;
  localparam int RAMP_WIDTH = 3;

  // mode flag bits
  localparam int MODE_INV_L = 0;
  localparam int MODE_INV_R = 1;
  localparam int MODE_SWAP  = 2;
  localparam int MODE_MONO  = 3;

  localparam longint SAT_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_MIN = -SAT_MAX - 1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
  } in_data_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } out_data_t;

  typedef struct packed {
    logic                busy;
    logic [3:0]          mode;
    logic [3:0][CW-1:0]  vals;
  } ctl_t;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [WIDE-1:0] v
  );
    logic signed [SAMPLE_BITS-1:0] res;
    if (v > WIDE'(SAT_MAX)) begin
      res = SAMPLE_BITS'(SAT_MAX);
    end else if (v < WIDE'(SAT_MIN)) begin
      res = SAMPLE_BITS'(SAT_MIN);
    end else begin
      res = SAMPLE_BITS'(v);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[sv/sgpw_div.sv]
// sgpw_div: restoring serial divider, one quotient bit per cycle, truncates toward zero
// depends on sgpw_pkg
`default_nettype none

module sgpw_div import sgpw_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic signed [DIV_W-1:0]     dividend,
  input  wire logic [RAMP_COUNT_BITS-1:0]  divisor,
  output logic                             busy,
  output logic                             done,
  output logic [VAL_BITS-1:0]              quot
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]            mag_r;
  logic [RAMP_COUNT_BITS-1:0]  rem_r;
  logic                        neg_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        done_r;

  logic [RAMP_COUNT_BITS:0]    rem_sh;
  logic [RAMP_COUNT_BITS:0]    rem_sub;
  logic                        ge;
  logic [DIV_W-1:0]            abs_in;

  assign rem_sh  = {rem_r, mag_r[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign ge      = (rem_sh >= {1'b0, divisor});
  assign abs_in  = dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (start) begin
        mag_r <= abs_in;
        neg_r <= dividend[DIV_W-1];
        rem_r <= '0;
        cnt_r <= CNT_W'(DIV_W);
      end else if (cnt_r != '0) begin
        mag_r <= {mag_r[DIV_W-2:0], ge};
        rem_r <= ge ? rem_sub[RAMP_COUNT_BITS-1:0] : rem_sh[RAMP_COUNT_BITS-1:0];
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  assign busy = (cnt_r != '0) || done_r;
  assign done = done_r;
  assign quot = neg_r ? VAL_BITS'(-mag_r) : VAL_BITS'(mag_r);

endmodule

`default_nettype wire

[sv/sgpw_ctrl.sv]
// sgpw_ctrl: configuration registers and the four smoothing ramps
// depends on sgpw_pkg and sgpw_div (ramp step division)
`default_nettype none

module sgpw_ctrl import sgpw_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CTRL_BITS-1:0]  cfg_data,
  input  wire logic                  adv,
  output ctl_t                       ctl
);

  logic [3:0][CTRL_BITS-1:0]        tgt_r;
  logic [RAMP_COUNT_BITS-1:0]       len_r;
  logic [3:0]                       mode_r;
  logic [3:0][VAL_BITS-1:0]         val_r;
  logic [3:0][VAL_BITS-1:0]         step_r;
  logic [3:0][RAMP_COUNT_BITS-1:0]  rem_r;
  logic [1:0]                       pend_r;

  logic                 wr;
  logic [1:0]           wk;
  logic                 is_tgt;
  logic                 tgt_chg;
  logic                 div_start;
  logic signed [DIV_W-1:0] diff;
  logic                 div_busy;
  logic                 div_done;
  logic [VAL_BITS-1:0]  quot;

  function automatic logic [VAL_BITS-1:0] tgt_val(input logic [CTRL_BITS-1:0] t);
    return VAL_BITS'({t, {EXTRA_FRAC{1'b0}}});
  endfunction

  assign wr        = cfg_valid && cfg_ready;
  assign wk        = cfg_index[1:0];
  assign is_tgt    = (cfg_index == REG_GAIN) || (cfg_index == REG_PAN_L) ||
                     (cfg_index == REG_PAN_R) || (cfg_index == REG_WIDTH);
  assign tgt_chg   = (tgt_r[wk] != cfg_data);
  assign diff      = $signed({1'b0, tgt_val(cfg_data)}) - $signed({1'b0, val_r[wk]});
  assign div_start = wr && is_tgt && tgt_chg && (len_r != '0);

  sgpw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff),
    .divisor  (len_r),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r[RAMP_GAIN]  <= GAIN_RESET;
      tgt_r[RAMP_PAN_L] <= PAN_RESET;
      tgt_r[RAMP_PAN_R] <= PAN_RESET;
      tgt_r[RAMP_WIDTH] <= PAN_RESET;
      val_r[RAMP_GAIN]  <= tgt_val(GAIN_RESET);
      val_r[RAMP_PAN_L] <= tgt_val(PAN_RESET);
      val_r[RAMP_PAN_R] <= tgt_val(PAN_RESET);
      val_r[RAMP_WIDTH] <= tgt_val(PAN_RESET);
      step_r            <= '0;
      rem_r             <= '0;
      len_r             <= RAMP_LEN_RESET;
      mode_r            <= '0;
      pend_r            <= '0;
    end else begin
      if (div_done) begin
        step_r[pend_r] <= quot;
      end
      if (adv) begin
        for (int k = 0; k < 4; k++) begin
          if (rem_r[k] == '0) begin
            val_r[k] <= tgt_val(tgt_r[k]);
          end else begin
            rem_r[k] <= rem_r[k] - RAMP_COUNT_BITS'(1);
            if (rem_r[k] != RAMP_COUNT_BITS'(1)) begin
              val_r[k] <= val_r[k] + step_r[k];
            end else begin
              val_r[k] <= tgt_val(tgt_r[k]);
            end
          end
        end
      end
      if (wr) begin
        unique case (cfg_index) inside
          REG_GAIN, REG_PAN_L, REG_PAN_R, REG_WIDTH: begin
            if (tgt_chg) begin
              tgt_r[wk] <= cfg_data;
              if (len_r == '0) begin
                val_r[wk]  <= tgt_val(cfg_data);
                step_r[wk] <= '0;
                rem_r[wk]  <= '0;
              end else begin
                rem_r[wk] <= len_r;
                pend_r    <= wk;
              end
            end
          end
          REG_LEN: begin
            len_r <= cfg_data[RAMP_COUNT_BITS-1:0];
            for (int k = 0; k < 4; k++) begin
              val_r[k]  <= tgt_val(tgt_r[k]);
              step_r[k] <= '0;
              rem_r[k]  <= '0;
            end
          end
          REG_MODE: begin
            mode_r <= cfg_data[3:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign cfg_ready = !div_busy;

  always_comb begin
    ctl.busy = div_busy;
    ctl.mode = mode_r;
    for (int k = 0; k < 4; k++) begin
      ctl.vals[k] = val_r[k][VAL_BITS-1:EXTRA_FRAC];
    end
  end

endmodule

`default_nettype wire

[sv/sgpw_mul.sv]
// sgpw_mul: shared signed by unsigned multiplier with registered product
// depends on sgpw_pkg
`default_nettype none

module sgpw_mul import sgpw_pkg::*; (
  input  wire logic                  clk,
  input  wire logic signed [AW-1:0]  a,
  input  wire logic [CW-1:0]         b,
  output logic signed [PW-1:0]       prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= a * $signed({1'b0, b});
  end

endmodule

`default_nettype wire

[sv/stereo_gain_pan_width.sv]
// stereo_gain_pan_width: top level, sample sequencer around one shared multiplier
// a stereo sample runs the chain of five products through the single multiplier, a mono
// sample only the two gain products; no new sample is taken until the sequencer is idle again
// a target write that starts a ramp holds cfg_ready and in_stall while the serial divider works out the ramp step
// reset (rst_n, synchronous): targets and ramps at 1.0, ramp length 882, mode 0, no output
// depends on sgpw_pkg, sgpw_ctrl, sgpw_div, sgpw_mul
`default_nettype none

module stereo_gain_pan_width import sgpw_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // sample requests
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_data_t              in_data,
  // result requests
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_data_t                  out_data,
  // register writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CTRL_BITS-1:0]  cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_ADV, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_OUT
  } state_t;

  state_t                         state_r;
  logic signed [SAMPLE_BITS-1:0]  l_r;
  logic signed [SAMPLE_BITS-1:0]  r_r;
  logic signed [AW-1:0]           a_r;   // left path / mid / saturated left
  logic signed [AW-1:0]           b_r;   // right path / saturated right
  logic                           out_valid_r;
  out_data_t                      out_data_r;

  ctl_t                           ctl;
  logic signed [AW-1:0]           mul_a;
  logic [CW-1:0]                  mul_b;
  logic signed [PW-1:0]           prod;

  logic signed [AW-1:0]           tg;      // product after gain shift
  logic signed [AW-1:0]           tp;      // product after pan shift
  logic signed [WIDE-1:0]         side;
  logic signed [AW:0]             sum_ab;
  logic signed [AW-1:0]           mid;
  logic signed [WIDE-1:0]         mid_w;
  logic signed [WIDE-1:0]         lo_w;
  logic signed [WIDE-1:0]         ro_w;
  logic                           neg_l;
  logic                           mono;
  logic                           swap;

  // config registers and smoothed controls
  sgpw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .adv       (state_r == S_ADV),
    .ctl       (ctl)
  );

  // one multiplier, operands picked by the sequencer step
  sgpw_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  assign mono  = ctl.mode[MODE_MONO];
  assign swap  = ctl.mode[MODE_SWAP];
  // mono negates once per set inversion bit
  assign neg_l = ctl.mode[MODE_INV_L] ^ (mono & ctl.mode[MODE_INV_R]);

  always_comb begin
    case (state_r)
      S_M1: begin
        mul_a = AW'(l_r);
        mul_b = ctl.vals[RAMP_GAIN];
      end
      S_M2: begin
        mul_a = AW'(r_r);
        mul_b = ctl.vals[RAMP_GAIN];
      end
      S_M4: begin
        mul_a = swap ? b_r : a_r;
        mul_b = ctl.vals[RAMP_PAN_L];
      end
      S_M5: begin
        mul_a = swap ? a_r : b_r;
        mul_b = ctl.vals[RAMP_PAN_R];
      end
      S_M7: begin
        mul_a = a_r - b_r;
        mul_b = ctl.vals[RAMP_WIDTH];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // floor shifts of the registered product
  assign tg     = AW'(prod >>> GAIN_SH);
  assign tp     = AW'(prod >>> PAN_SH);
  assign side   = WIDE'(prod >>> SIDE_SH);
  assign sum_ab = {a_r[AW-1], a_r} + {b_r[AW-1], b_r};
  assign mid    = AW'(sum_ab >>> 1);
  assign mid_w  = WIDE'(a_r);
  assign lo_w   = mid_w + side;
  assign ro_w   = mid_w - side;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // result taken downstream; the output step reloads the register itself
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            l_r     <= in_data.left_in;
            r_r     <= in_data.right_in;
            state_r <= S_ADV;
          end
        end
        // ramps step once per sample
        S_ADV: state_r <= S_M1;
        S_M1:  state_r <= S_M2;
        S_M2: begin
          a_r     <= neg_l ? -tg : tg;
          state_r <= S_M3;
        end
        S_M3: begin
          if (mono) begin
            // mono result is ready, right output fixed at zero
            a_r     <= AW'(sat_sample(WIDE'(a_r)));
            b_r     <= '0;
            state_r <= S_OUT;
          end else begin
            b_r     <= ctl.mode[MODE_INV_R] ? -tg : tg;
            state_r <= S_M4;
          end
        end
        S_M4: state_r <= S_M5;
        S_M5: begin
          a_r     <= tp;
          state_r <= S_M6;
        end
        S_M6: begin
          b_r     <= tp;
          state_r <= S_M7;
        end
        // side product goes into the multiplier, mid kept in a_r
        S_M7: begin
          a_r     <= mid;
          state_r <= S_M8;
        end
        S_M8: begin
          a_r     <= AW'(sat_sample(lo_w));
          b_r     <= AW'(sat_sample(ro_w));
          state_r <= S_OUT;
        end
        // wait for the output register to free up
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r          <= 1'b1;
            out_data_r.left_out  <= SAMPLE_BITS'(a_r);
            out_data_r.right_out <= SAMPLE_BITS'(b_r);
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // no new sample while the sequencer runs or a ramp step is being divided
  assign in_stall  = (state_r != S_IDLE) || ctl.busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ramp advance happens only right after a sample request is taken
  a_adv_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADV) |-> $past(in_valid && !in_stall))
    else $error("ramp advance without a sample request");

  // a fresh result only comes out of the output wait step
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("out_valid raised outside the output step");

  // once the output register is free the result is posted and the sequencer idles
  a_out_post: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !(out_valid_r && out_stall)) |=>
      (out_valid_r && state_r == S_IDLE))
    else $error("result not posted when output register was free");

endmodule

`default_nettype wire
